// ----- rtl/core/fic_pkg.sv -----
// Shared types, constants and the byte-wide CRC-32 update for the image checker.
// Used by every module of the block; depends on nothing.
package fic_pkg;

  localparam int unsigned PARTITION_BYTES_DEFAULT = 131072;
  localparam logic [31:0] BASE_ADDRESS_RESET = 32'h0802_0000;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [1:0] STATUS_INTACT = 2'd0;
  localparam logic [1:0] STATUS_CORRUPT = 2'd1;
  localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;
  localparam logic [1:0] STATUS_MISALIGNED = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_DATA    = 5'b00100,
    PH_TRAILER = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] computed;
    logic [31:0] stored;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/fic_step.sv -----
// Next-state and result logic for one image byte of the CRC checker.
// Depends on fic_pkg for the phase type, status codes and the CRC update.
module fic_step #(
  parameter int unsigned PARTITION_BYTES = fic_pkg::PARTITION_BYTES_DEFAULT,
  parameter int unsigned POS_W = $clog2(PARTITION_BYTES)
) (
  input  fic_pkg::phase_t  phase,
  input  logic [POS_W-1:0] pos,
  input  logic [POS_W-1:0] len,
  input  logic [31:0]      crc,
  input  logic [31:0]      trailer,
  input  logic [1:0]       base_low,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  output fic_pkg::phase_t  phase_next,
  output logic [POS_W-1:0] pos_next,
  output logic [POS_W-1:0] len_next,
  output logic [31:0]      crc_next,
  output logic [31:0]      trailer_next,
  output logic             emit,
  output fic_pkg::result_t result
);
  import fic_pkg::*;

  localparam logic [31:0] MaxLength = 32'(PARTITION_BYTES - 4);

  phase_t           ph;
  logic [POS_W-1:0] p;
  logic [POS_W-1:0] pos_inc;
  logic [31:0]      c;
  logic [31:0]      t;
  logic [31:0]      t_new;
  logic [31:0]      comp;
  logic [1:0]       k;
  logic             len_ok;

  always_comb begin
    ph = phase;
    p = pos;
    c = crc;
    t = trailer;
    phase_next = phase;
    pos_next = pos;
    len_next = len;
    crc_next = crc;
    trailer_next = trailer;
    emit = 1'b0;
    result = '{status: STATUS_BAD_LENGTH, computed: 32'd0, stored: 32'hFFFF_FFFF};
    t_new = '0;
    comp = '0;
    k = '0;
    len_ok = 1'b0;

    if (first_byte) begin
      ph = PH_LEN;
      p = '0;
      c = CRC_INIT;
      t = '0;
      len_next = '0;
    end
    pos_inc = p + POS_W'(1);

    if (first_byte && base_low != 2'd0) begin
      emit = 1'b1;
      phase_next = PH_DONE;
      result.status = STATUS_MISALIGNED;
    end else begin
      case (ph)
        PH_LEN: begin
          crc_next = crc_byte(c, data_byte);
          t_new = t | ({24'd0, data_byte} << {p[1:0], 3'b000});
          trailer_next = t_new;
          pos_next = pos_inc;
          phase_next = PH_LEN;
          if (p[1:0] == 2'd3) begin
            len_ok = (t_new >= 32'd4) && (t_new <= MaxLength) && (t_new[1:0] == 2'd0);
            if (!len_ok) begin
              emit = 1'b1;
              phase_next = PH_DONE;
            end else begin
              len_next = t_new[POS_W-1:0];
              trailer_next = '0;
              phase_next = (t_new == 32'd4) ? PH_TRAILER : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          crc_next = crc_byte(c, data_byte);
          pos_next = pos_inc;
          if (pos_inc >= len) begin
            phase_next = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          k = 2'(p - len);
          t_new = t | ({24'd0, data_byte} << {k, 3'b000});
          trailer_next = t_new;
          pos_next = pos_inc;
          if (k == 2'd3) begin
            comp = ~c;
            emit = 1'b1;
            phase_next = PH_DONE;
            result.status = (comp == t_new) ? STATUS_INTACT : STATUS_CORRUPT;
            result.computed = comp;
            result.stored = t_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/firmware_image_crc_checker.sv -----
// Top level of the length-prefixed firmware image CRC-32 checker.
// Holds the input, state and result registers; depends on fic_pkg and fic_step.
//
//   port group   dir  transfer carries
//   s_axis       in   one image byte, tuser marks the first byte of an image
//   m_axis       out  one check result: status, computed CRC, stored CRC
//   cfg          in   write of the partition base address
//
// One byte is taken every cycle unless a result stalls; the byte that ends the check
// passes the input register and then the result register before its result leaves.
// Reset clears the pipeline valids and the check state, and loads the default base.
// A stalled result holds the result register; the input register then fills and
// s_axis_tready falls until the result is taken.
module firmware_image_crc_checker #(
  parameter int unsigned PARTITION_BYTES = fic_pkg::PARTITION_BYTES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fic_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_byte
  input  logic [0:0]                        s_axis_tuser,  // first_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fic_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // check_status, computed_crc,
                                                           // stored_crc, zero pad
  input  logic                              cfg_we,
  input  logic [31:0]                       cfg_wdata
);
  import fic_pkg::*;

  localparam int unsigned POS_W = $clog2(PARTITION_BYTES);

  logic [31:0]      image_base_address;
  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_first;
  logic             advance;

  phase_t           phase;
  phase_t           phase_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] len;
  logic [POS_W-1:0] len_next;
  logic [31:0]      crc;
  logic [31:0]      crc_next;
  logic [31:0]      trailer;
  logic [31:0]      trailer_next;
  logic             emit;
  result_t          result;
  result_t          out_result;
  logic             out_valid;

  assign advance = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {6'd0, out_result.stored, out_result.computed, out_result.status};

  fic_step #(
    .PARTITION_BYTES(PARTITION_BYTES),
    .POS_W(POS_W)
  ) u_step (
    .phase(phase),
    .pos(pos),
    .len(len),
    .crc(crc),
    .trailer(trailer),
    .base_low(image_base_address[1:0]),
    .data_byte(in_byte),
    .first_byte(in_first),
    .phase_next(phase_next),
    .pos_next(pos_next),
    .len_next(len_next),
    .crc_next(crc_next),
    .trailer_next(trailer_next),
    .emit(emit),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base_address <= BASE_ADDRESS_RESET;
    end else if (cfg_we) begin
      image_base_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata[7:0];
      in_first <= s_axis_tuser[0];
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos <= '0;
      len <= '0;
      crc <= CRC_INIT;
      trailer <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && emit;
      if (in_valid) begin
        phase <= phase_next;
        pos <= pos_next;
        len <= len_next;
        crc <= crc_next;
        trailer <= trailer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && emit) begin
      out_result <= result;
    end
  end

endmodule

// ----- rtl/core/fic_checker.sv -----
// Port-level checks for the firmware image CRC checker, bound to its top level.
// Depends on fic_pkg for the result layout and status codes.
module fic_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fic_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import fic_pkg::*;

  logic [1:0]  status;
  logic [31:0] computed;
  logic [31:0] stored;

  assign status = m_axis_tdata[1:0];
  assign computed = m_axis_tdata[33:2];
  assign stored = m_axis_tdata[65:34];

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result offered right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed or vanished.");

  a_error_crcs: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (status == STATUS_BAD_LENGTH || status == STATUS_MISALIGNED)
    |-> computed == 32'd0 && stored == 32'hFFFF_FFFF)
    else $error("Error result carries CRC values.");

  a_crc_verdict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (status == STATUS_INTACT || status == STATUS_CORRUPT)
    |-> (computed == stored) == (status == STATUS_INTACT) && m_axis_tdata[71:66] == 6'd0)
    else $error("Verdict disagrees with the reported CRCs.");

endmodule

bind firmware_image_crc_checker fic_checker u_fic_checker (
  .clk(clk),
  .rst(rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
